>>> rtl/core/sbo_pkg.sv
`timescale 1ns / 1ps

package sbo_pkg;

    // Screen and sprite limits.
    localparam int SCREEN_W       = 320;
    localparam int SCREEN_H       = 200;
    localparam int MAX_SPRITE_DIM = 64;

    // Field widths.
    localparam int IDX_W      = 6;
    localparam int DIM_W      = 7;
    localparam int POS_W      = 11;
    localparam int DEST_W     = 12;
    localparam int COL_W      = 8;
    localparam int ORIENT_W   = 3;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // Queue between the front and the back.
    localparam int MID_DEPTH = 2;
    localparam int MID_PTR_W = 1;
    localparam int MID_CNT_W = 2;

    // Result buffer in the back.
    localparam int OUT_DEPTH = 2;
    localparam int OUT_PTR_W = 1;
    localparam int OUT_CNT_W = 2;

    // Special colours.
    localparam logic [COL_W-1:0] KEY_COLOR   = 8'hff;
    localparam logic [COL_W-1:0] STENCIL_ONE = 8'h01;

    // Orientation codes.
    localparam logic [ORIENT_W-1:0] ORIENT_NONE   = 3'd0;
    localparam logic [ORIENT_W-1:0] ORIENT_ROT90  = 3'd1;
    localparam logic [ORIENT_W-1:0] ORIENT_ROT180 = 3'd2;
    localparam logic [ORIENT_W-1:0] ORIENT_ROT270 = 3'd3;
    localparam logic [ORIENT_W-1:0] ORIENT_MIRX   = 3'd4;
    localparam logic [ORIENT_W-1:0] ORIENT_MIRY   = 3'd5;

    // Draw modes.
    localparam logic [MODE_W-1:0] MODE_KEYED   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RAW     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STENCIL = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_POS_X         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DRAW_MODE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STENCIL_COLOR = 3'd6;

    // Configuration register bank as seen by the datapath.
    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [DIM_W-1:0]        sprite_width;
        logic [DIM_W-1:0]        sprite_height;
        logic [ORIENT_W-1:0]     orientation;
        logic [MODE_W-1:0]       draw_mode;
        logic [COL_W-1:0]        stencil_color;
    } cfg_t;

    // One classified pixel on its way from the front to the back.
    typedef struct packed {
        logic [COL_W-1:0] pixel;
        logic [IDX_W-1:0] ix;
        logic [IDX_W-1:0] iy;
        logic             done;
    } item_t;

    // One framebuffer write request.
    typedef struct packed {
        logic                     write_enable;
        logic signed [DEST_W-1:0] dest_x;
        logic signed [DEST_W-1:0] dest_y;
        logic [COL_W-1:0]         color;
        logic                     sprite_done;
    } res_t;

    // A size of zero counts as one, a size above the maximum as the maximum.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > DIM_W'(MAX_SPRITE_DIM))
            r = DIM_W'(MAX_SPRITE_DIM);
        else
            r = v;
        return r;
    endfunction

endpackage

>>> rtl/core/sprite_blit_orient_clip.sv
`timescale 1ns / 1ps
// An accepted pixel is held in the queue and then in the result buffer, from which its
// write request is offered on the result ports.
// Throughput: one pixel per cycle unless a queue is full; the front position counters
// and back orientation adders each handle one beat a cycle, with a two-entry queue between them.
// Reset (rst_n low, asynchronous): registers return to their defaults, the position
// counters clear and both queues empty.

module sprite_blit_orient_clip
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          pixel,
    output logic                empty,
    input  logic                pop,
    output logic                write_enable,
    output logic signed [11:0]  dest_x,
    output logic signed [11:0]  dest_y,
    output logic [7:0]          color,
    output logic                sprite_done,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [10:0]         cfg_data
);

    sbo_pkg::cfg_t  cfg_reg;
    sbo_pkg::item_t front_item, back_item;
    sbo_pkg::res_t  res;
    logic           mid_push, mid_pop, mid_full, mid_empty;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pos_x         <= '0;
            cfg_reg.pos_y         <= '0;
            cfg_reg.sprite_width  <= sbo_pkg::DIM_W'(16);
            cfg_reg.sprite_height <= sbo_pkg::DIM_W'(16);
            cfg_reg.orientation   <= sbo_pkg::ORIENT_NONE;
            cfg_reg.draw_mode     <= sbo_pkg::MODE_KEYED;
            cfg_reg.stencil_color <= sbo_pkg::COL_W'(15);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sbo_pkg::REG_POS_X:
                    cfg_reg.pos_x <= $signed(cfg_data[sbo_pkg::POS_W-1:0]);
                sbo_pkg::REG_POS_Y:
                    cfg_reg.pos_y <= $signed(cfg_data[sbo_pkg::POS_W-1:0]);
                sbo_pkg::REG_SPRITE_WIDTH:
                    cfg_reg.sprite_width <= cfg_data[sbo_pkg::DIM_W-1:0];
                sbo_pkg::REG_SPRITE_HEIGHT:
                    cfg_reg.sprite_height <= cfg_data[sbo_pkg::DIM_W-1:0];
                sbo_pkg::REG_ORIENTATION:
                    cfg_reg.orientation <= cfg_data[sbo_pkg::ORIENT_W-1:0];
                sbo_pkg::REG_DRAW_MODE:
                    cfg_reg.draw_mode <= cfg_data[sbo_pkg::MODE_W-1:0];
                sbo_pkg::REG_STENCIL_COLOR:
                    cfg_reg.stencil_color <= cfg_data[sbo_pkg::COL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Front: accepts pixels and tags them with their sprite position.
    sbo_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .push     (push),
        .pixel    (pixel),
        .mid_full (mid_full),
        .mid_push (mid_push),
        .mid_item (front_item)
    );

    // Queue between front and back.
    sbo_fifo u_mid
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_push),
        .wr_data (front_item),
        .rd_en   (mid_pop),
        .rd_data (back_item),
        .full    (mid_full),
        .empty   (mid_empty)
    );

    // Back: orients, clips keyed pixels and buffers the write requests.
    sbo_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .mid_empty (mid_empty),
        .mid_item  (back_item),
        .mid_pop   (mid_pop),
        .pop       (pop),
        .empty     (empty),
        .res       (res)
    );

    assign full         = mid_full;
    assign write_enable = res.write_enable;
    assign dest_x       = res.dest_x;
    assign dest_y       = res.dest_y;
    assign color        = res.color;
    assign sprite_done  = res.sprite_done;

endmodule

>>> rtl/core/sbo_front.sv
`timescale 1ns / 1ps

module sbo_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  sbo_pkg::cfg_t    cfg,
    input  logic             push,
    input  logic [7:0]       pixel,
    input  logic             mid_full,
    output logic             mid_push,
    output sbo_pkg::item_t   mid_item
);

    logic [sbo_pkg::IDX_W-1:0] ix_reg, ix_next;
    logic [sbo_pkg::IDX_W-1:0] iy_reg, iy_next;
    logic [sbo_pkg::DIM_W-1:0] w, h;
    logic [sbo_pkg::DIM_W-1:0] ix_inc, iy_inc;
    logic                      wrap_row, wrap_col;

    // A beat is taken whenever the queue has room.
    assign mid_push = push && !mid_full;

    // Position tracking: the row runs fastest, then the column.
    always_comb
    begin
        w        = sbo_pkg::clamp_dim(cfg.sprite_width);
        h        = sbo_pkg::clamp_dim(cfg.sprite_height);
        iy_inc   = {1'b0, iy_reg} + sbo_pkg::DIM_W'(1);
        ix_inc   = {1'b0, ix_reg} + sbo_pkg::DIM_W'(1);
        wrap_row = (iy_inc >= h);
        wrap_col = (ix_inc >= w);
        ix_next  = ix_reg;
        iy_next  = iy_reg;
        if (mid_push)
        begin
            if (wrap_row)
            begin
                iy_next = '0;
                ix_next = wrap_col ? '0 : ix_inc[sbo_pkg::IDX_W-1:0];
            end
            else
            begin
                iy_next = iy_inc[sbo_pkg::IDX_W-1:0];
            end
        end
    end

    // The item carries the position as held before the advance.
    always_comb
    begin
        mid_item.pixel = pixel;
        mid_item.ix    = ix_reg;
        mid_item.iy    = iy_reg;
        mid_item.done  = wrap_row && wrap_col;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ix_reg <= '0;
            iy_reg <= '0;
        end
        else
        begin
            ix_reg <= ix_next;
            iy_reg <= iy_next;
        end
    end

endmodule

>>> rtl/core/sbo_fifo.sv
`timescale 1ns / 1ps

module sbo_fifo
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  sbo_pkg::item_t wr_data,
    input  logic           rd_en,
    output sbo_pkg::item_t rd_data,
    output logic           full,
    output logic           empty
);

    sbo_pkg::item_t                mem [sbo_pkg::MID_DEPTH];
    logic [sbo_pkg::MID_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [sbo_pkg::MID_CNT_W-1:0] count_reg;
    logic                          do_wr, do_rd;

    assign full    = (count_reg == sbo_pkg::MID_CNT_W'(sbo_pkg::MID_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    // Storage holds payload only and needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == sbo_pkg::MID_PTR_W'(sbo_pkg::MID_DEPTH - 1))
                              ? '0 : wr_ptr_reg + sbo_pkg::MID_PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == sbo_pkg::MID_PTR_W'(sbo_pkg::MID_DEPTH - 1))
                              ? '0 : rd_ptr_reg + sbo_pkg::MID_PTR_W'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + sbo_pkg::MID_CNT_W'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - sbo_pkg::MID_CNT_W'(1);
        end
    end

endmodule

>>> rtl/core/sbo_back.sv
`timescale 1ns / 1ps

module sbo_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  sbo_pkg::cfg_t       cfg,
    input  logic                mid_empty,
    input  sbo_pkg::item_t      mid_item,
    output logic                mid_pop,
    input  logic                pop,
    output logic                empty,
    output sbo_pkg::res_t       res
);

    logic signed [sbo_pkg::DEST_W-1:0] bx, by, ix_s, iy_s, w_s, h_s;
    logic signed [sbo_pkg::DEST_W-1:0] rx, ry, dx, dy;
    logic [sbo_pkg::DIM_W-1:0]         w, h;
    logic                              orient_ok, on_screen, we;
    logic [sbo_pkg::COL_W-1:0]         col;
    sbo_pkg::res_t                     new_res;

    sbo_pkg::res_t                 obuf [sbo_pkg::OUT_DEPTH];
    logic [sbo_pkg::OUT_PTR_W-1:0] owr_reg, ord_reg;
    logic [sbo_pkg::OUT_CNT_W-1:0] ocnt_reg;
    logic                          out_pop;

    // Operands extended to the destination width.
    always_comb
    begin
        w    = sbo_pkg::clamp_dim(cfg.sprite_width);
        h    = sbo_pkg::clamp_dim(cfg.sprite_height);
        bx   = sbo_pkg::DEST_W'(cfg.pos_x);
        by   = sbo_pkg::DEST_W'(cfg.pos_y);
        ix_s = $signed({{(sbo_pkg::DEST_W - sbo_pkg::IDX_W){1'b0}}, mid_item.ix});
        iy_s = $signed({{(sbo_pkg::DEST_W - sbo_pkg::IDX_W){1'b0}}, mid_item.iy});
        w_s  = $signed({{(sbo_pkg::DEST_W - sbo_pkg::DIM_W){1'b0}}, w});
        h_s  = $signed({{(sbo_pkg::DEST_W - sbo_pkg::DIM_W){1'b0}}, h});
        rx   = w_s - ix_s - sbo_pkg::DEST_W'(1);
        ry   = h_s - iy_s - sbo_pkg::DEST_W'(1);
    end

    // Orientation of the destination around the top-left corner.
    always_comb
    begin
        orient_ok = 1'b1;
        dx        = bx + ix_s;
        dy        = by + iy_s;
        unique case (cfg.orientation)
            sbo_pkg::ORIENT_NONE:
            begin
            end
            sbo_pkg::ORIENT_ROT90:
            begin
                dx = bx + ry;
                dy = by + ix_s;
            end
            sbo_pkg::ORIENT_ROT180:
            begin
                dx = bx + rx;
                dy = by + ry;
            end
            sbo_pkg::ORIENT_ROT270:
            begin
                dx = bx + iy_s;
                dy = by + rx;
            end
            sbo_pkg::ORIENT_MIRX:
            begin
                dx = bx + rx;
            end
            sbo_pkg::ORIENT_MIRY:
            begin
                dy = by + ry;
            end
            default:
            begin
                orient_ok = 1'b0;
            end
        endcase
    end

    // Draw mode and orientation decide the enable; draw mode decides the colour.
    always_comb
    begin
        on_screen = (dx >= 0) && (dx < sbo_pkg::DEST_W'(sbo_pkg::SCREEN_W))
                 && (dy >= 0) && (dy < sbo_pkg::DEST_W'(sbo_pkg::SCREEN_H));
        col = mid_item.pixel;
        unique case (cfg.draw_mode)
            sbo_pkg::MODE_KEYED:
            begin
                we = (mid_item.pixel != sbo_pkg::KEY_COLOR) && on_screen;
            end
            sbo_pkg::MODE_RAW:
            begin
                we = 1'b1;
            end
            sbo_pkg::MODE_STENCIL:
            begin
                we  = (mid_item.pixel == sbo_pkg::STENCIL_ONE);
                col = cfg.stencil_color;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
        new_res.write_enable = we && orient_ok;
        new_res.dest_x       = dx;
        new_res.dest_y       = dy;
        new_res.color        = col;
        new_res.sprite_done  = mid_item.done;
    end

    // Result buffer: takes a new beat whenever it has a free slot.
    assign mid_pop = !mid_empty && (ocnt_reg != sbo_pkg::OUT_CNT_W'(sbo_pkg::OUT_DEPTH));
    assign out_pop = pop && (ocnt_reg != '0);
    assign empty   = (ocnt_reg == '0);
    assign res     = obuf[ord_reg];

    always_ff @(posedge clk)
    begin
        if (mid_pop)
            obuf[owr_reg] <= new_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_reg  <= '0;
            ord_reg  <= '0;
            ocnt_reg <= '0;
        end
        else
        begin
            if (mid_pop)
                owr_reg <= (owr_reg == sbo_pkg::OUT_PTR_W'(sbo_pkg::OUT_DEPTH - 1))
                           ? '0 : owr_reg + sbo_pkg::OUT_PTR_W'(1);
            if (out_pop)
                ord_reg <= (ord_reg == sbo_pkg::OUT_PTR_W'(sbo_pkg::OUT_DEPTH - 1))
                           ? '0 : ord_reg + sbo_pkg::OUT_PTR_W'(1);
            if (mid_pop && !out_pop)
                ocnt_reg <= ocnt_reg + sbo_pkg::OUT_CNT_W'(1);
            else if (out_pop && !mid_pop)
                ocnt_reg <= ocnt_reg - sbo_pkg::OUT_CNT_W'(1);
        end
    end

endmodule

>>> rtl/core/sbo_checker.sv
`timescale 1ns / 1ps

module sbo_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               full,
    input  logic               empty,
    input  logic               pop,
    input  logic               write_enable,
    input  logic signed [11:0] dest_x,
    input  logic signed [11:0] dest_y,
    input  logic [7:0]         color,
    input  logic               sprite_done
);

    // While reset is held both sides show an empty block.
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> (empty && !full))
        else $error("block not idle during reset");

    // The input side backs up only behind a waiting result.
    a_full_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("input full with no result waiting");

    // A result that is not taken stays offered.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting result withdrawn");

    // A result that is not taken keeps its payload.
    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(write_enable) && $stable(dest_x) && $stable(dest_y)
                              && $stable(color) && $stable(sprite_done)))
        else $error("waiting result changed");

endmodule

bind sprite_blit_orient_clip sbo_checker u_sbo_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .write_enable (write_enable),
    .dest_x       (dest_x),
    .dest_y       (dest_y),
    .color        (color),
    .sprite_done  (sprite_done)
);
